/* hw/rtl/dbrq_pkg.sv */
// Shared constants, codes and the queue word type of the depth bucket render queue.
`default_nettype none
package dbrq_pkg;
    localparam int DEPTH_BUCKETS_DEF = 100;
    localparam int CAPACITY_DEF      = 64;

    localparam int ID_W       = 16;
    localparam int POS_W      = 32;
    localparam int ROT_W      = 16;
    localparam int KIND_W     = 2;
    localparam int BUCKET_W   = 7;   // width of the depth_bucket result field
    localparam int BKT_MAX_W  = 8;   // enough for the largest bucket count
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 24;

    localparam int DIFF_W  = 33;
    localparam int COEF_W  = 21;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = COEF_W + MUL_B_W;
    localparam int SUM_W   = 34;
    localparam int ACC_W   = 56;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NODE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CAM_POS_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_POS_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_POS_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_ROT_W = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_ROT_X = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_ROT_Y = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CAM_ROT_Z = 3'd6;

    typedef struct packed {
        logic                 op;
        logic [ID_W-1:0]      node_id;
        logic [BKT_MAX_W-1:0] bucket;
    } cmd_t;
endpackage
`default_nettype wire

/* hw/rtl/dbrq_fifo.sv */
// Short command queue between the classifying front and the list back end.
`default_nettype none
module dbrq_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire dbrq_pkg::cmd_t push_data,
    output logic                full,
    input  wire                 pop,
    output dbrq_pkg::cmd_t      pop_data,
    output logic                empty
);
    import dbrq_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full     = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push && !full) - (FIFO_AW+1)'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/dbrq_front.sv */
// Front end: camera registers, rotation coefficients and bucket classification.
`default_nettype none
module dbrq_front #(
    parameter int DEPTH_BUCKETS = dbrq_pkg::DEPTH_BUCKETS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [dbrq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [dbrq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [dbrq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                              s_tuser,
    output logic                             q_push,
    output dbrq_pkg::cmd_t                   q_data,
    input  wire                              q_full
);
    import dbrq_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_COEF = 3'd1;
    localparam logic [2:0] F_CFIN = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_BKT  = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    localparam logic [3:0] COEF_STEPS = 4'd8;
    localparam logic [3:0] MUL_STEPS  = 4'd6;
    localparam logic [1:0] DST_ACC    = 2'd3;

    logic [2:0] state_reg;
    logic [3:0] cnt_reg;
    logic       dirty_reg;

    logic signed [POS_W-1:0]  cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [ROT_W-1:0]  rot_w_reg, rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [COEF_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [SUM_W-1:0]  s1_reg, s2_reg, s3_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg, pneg_reg, psh_reg;
    logic [1:0]               pdst_reg;
    cmd_t                     cmd_reg;

    logic signed [COEF_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      issue, step_neg, step_sh;
    logic [1:0]                step_dst;
    logic signed [DIFF_W-1:0]  d_sel;
    logic signed [COEF_W-1:0]  c_sel;
    logic signed [ACC_W-1:0]   prod_ext, t_val;
    logic [ACC_W-31:0]         t_hi;
    logic [BKT_MAX_W-1:0]      bkt;
    logic                      accept;

    function automatic logic signed [COEF_W-1:0] rx(input logic signed [ROT_W-1:0] v);
        rx = COEF_W'(v);
    endfunction
    function automatic logic signed [MUL_B_W-1:0] ry(input logic signed [ROT_W-1:0] v);
        ry = MUL_B_W'(v);
    endfunction

    assign s_tready = (state_reg == F_IDLE) && !dirty_reg;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_data   = cmd_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        step_dst = DST_ACC;
        step_neg = 1'b0;
        step_sh  = 1'b0;
        issue    = 1'b0;
        d_sel    = dx_reg;
        c_sel    = cx_reg;
        if (state_reg == F_COEF && cnt_reg < COEF_STEPS) begin
            issue = 1'b1;
            case (cnt_reg[2:0])
                3'd0: begin mul_a = rx(rot_x_reg); mul_b = ry(rot_z_reg); step_dst = 2'd0; end
                3'd1: begin mul_a = rx(rot_w_reg); mul_b = ry(rot_y_reg); step_dst = 2'd0; end
                3'd2: begin mul_a = rx(rot_y_reg); mul_b = ry(rot_z_reg); step_dst = 2'd1; end
                3'd3: begin
                    mul_a = rx(rot_w_reg); mul_b = ry(rot_x_reg); step_dst = 2'd1;
                    step_neg = 1'b1;
                end
                3'd4: begin mul_a = rx(rot_w_reg); mul_b = ry(rot_w_reg); step_dst = 2'd2; end
                3'd5: begin
                    mul_a = rx(rot_x_reg); mul_b = ry(rot_x_reg); step_dst = 2'd2;
                    step_neg = 1'b1;
                end
                3'd6: begin
                    mul_a = rx(rot_y_reg); mul_b = ry(rot_y_reg); step_dst = 2'd2;
                    step_neg = 1'b1;
                end
                default: begin mul_a = rx(rot_z_reg); mul_b = ry(rot_z_reg); step_dst = 2'd2; end
            endcase
        end else if (state_reg == F_MUL && cnt_reg < MUL_STEPS) begin
            issue = 1'b1;
            case (cnt_reg[2:1])
                2'd0:    begin c_sel = cx_reg; d_sel = dx_reg; end
                2'd1:    begin c_sel = cy_reg; d_sel = dy_reg; end
                default: begin c_sel = cz_reg; d_sel = dz_reg; end
            endcase
            mul_a   = c_sel;
            step_sh = cnt_reg[0];
            mul_b   = cnt_reg[0] ? {{2{d_sel[DIFF_W-1]}}, d_sel[DIFF_W-1:17]}
                                 : {1'b0, d_sel[16:0]};
        end
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign t_val    = -acc_reg;
    assign t_hi     = t_val[ACC_W-1:30];

    always_comb begin
        if (t_val[ACC_W-1] || t_val == '0) begin
            bkt = '0;
        end else if (t_hi > (ACC_W-30)'(DEPTH_BUCKETS - 1)) begin
            bkt = BKT_MAX_W'(DEPTH_BUCKETS - 1);
        end else begin
            bkt = BKT_MAX_W'(t_hi);
        end
    end

    // Multiply into the product register, then accumulate it in the next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        pdst_reg <= step_dst;
        pneg_reg <= step_neg;
        psh_reg  <= step_sh;
        if (state_reg == F_IDLE && dirty_reg) begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end else if (pv_reg) begin
            case (pdst_reg)
                2'd0: s1_reg <= s1_reg + SUM_W'(prod_reg);
                2'd1: s2_reg <= pneg_reg ? s2_reg - SUM_W'(prod_reg) : s2_reg + SUM_W'(prod_reg);
                2'd2: s3_reg <= pneg_reg ? s3_reg - SUM_W'(prod_reg) : s3_reg + SUM_W'(prod_reg);
                default: acc_reg <= acc_reg + (psh_reg ? (prod_ext <<< 17) : prod_ext);
            endcase
        end
        if (accept) begin
            cmd_reg.op      <= s_tuser;
            cmd_reg.node_id <= s_tdata[15:0];
            cmd_reg.bucket  <= '0;
            dx_reg  <= DIFF_W'($signed(s_tdata[47:16])) - DIFF_W'(cam_x_reg);
            dy_reg  <= DIFF_W'($signed(s_tdata[79:48])) - DIFF_W'(cam_y_reg);
            dz_reg  <= DIFF_W'($signed(s_tdata[111:80])) - DIFF_W'(cam_z_reg);
            acc_reg <= '0;
        end
        if (state_reg == F_BKT) begin
            cmd_reg.bucket <= bkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            dirty_reg <= 1'b0;
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            rot_w_reg <= 16'sd16384;
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= 21'sd16384;
        end else begin
            pv_reg <= issue;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CAM_POS_X: cam_x_reg <= cfg_wdata;
                    REG_CAM_POS_Y: cam_y_reg <= cfg_wdata;
                    REG_CAM_POS_Z: cam_z_reg <= cfg_wdata;
                    REG_CAM_ROT_W: begin rot_w_reg <= cfg_wdata[15:0]; dirty_reg <= 1'b1; end
                    REG_CAM_ROT_X: begin rot_x_reg <= cfg_wdata[15:0]; dirty_reg <= 1'b1; end
                    REG_CAM_ROT_Y: begin rot_y_reg <= cfg_wdata[15:0]; dirty_reg <= 1'b1; end
                    REG_CAM_ROT_Z: begin rot_z_reg <= cfg_wdata[15:0]; dirty_reg <= 1'b1; end
                    default: ;
                endcase
            end
            case (state_reg)
                F_IDLE: begin
                    cnt_reg <= '0;
                    if (dirty_reg && !cfg_we) begin
                        state_reg <= F_COEF;
                    end else if (accept) begin
                        state_reg <= (s_tuser == OP_FLUSH) ? F_PUSH : F_MUL;
                    end
                end
                F_COEF: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == COEF_STEPS) begin
                        state_reg <= F_CFIN;
                    end
                end
                F_CFIN: begin
                    // floor(2s / 2^14) for the cross terms, floor(s / 2^14) for cz
                    cx_reg    <= COEF_W'(s1_reg >>> 13);
                    cy_reg    <= COEF_W'(s2_reg >>> 13);
                    cz_reg    <= COEF_W'(s3_reg >>> 14);
                    dirty_reg <= 1'b0;
                    state_reg <= F_IDLE;
                end
                F_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_STEPS) begin
                        state_reg <= F_BKT;
                    end
                end
                F_BKT:  state_reg <= F_PUSH;
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/dbrq_back.sv */
// Back end: per-bucket linked lists, flush walk and the output register.
`default_nettype none
module dbrq_back #(
    parameter int DEPTH_BUCKETS = dbrq_pkg::DEPTH_BUCKETS_DEF,
    parameter int CAPACITY      = dbrq_pkg::CAPACITY_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             q_empty,
    input  wire dbrq_pkg::cmd_t             q_data,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [dbrq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [dbrq_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import dbrq_pkg::*;

    localparam int BKT_W = $clog2(DEPTH_BUCKETS);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ADD  = 3'd1;
    localparam logic [2:0] B_SCAN = 3'd2;
    localparam logic [2:0] B_HT   = 3'd3;
    localparam logic [2:0] B_NODE = 3'd4;
    localparam logic [2:0] B_END  = 3'd5;

    logic [IDX_W-1:0] head_mem [DEPTH_BUCKETS];
    logic [IDX_W-1:0] tail_mem [DEPTH_BUCKETS];
    logic [IDX_W-1:0] link_mem [CAPACITY];
    logic [ID_W-1:0]  slot_mem [CAPACITY];

    logic [DEPTH_BUCKETS-1:0] valid_reg;
    logic [2:0]               state_reg;
    logic [CNT_W-1:0]         used_reg, n_reg;
    logic [BKT_W-1:0]         b_reg, add_b_reg;
    logic [ID_W-1:0]          add_id_reg;
    logic [IDX_W-1:0]         head_rd_reg, tail_rd_reg, link_rd_reg, cur_s_reg, cur_tail_reg;
    logic [ID_W-1:0]          slot_rd_reg;
    logic                     pend_valid_reg;
    logic [ID_W-1:0]          pend_id_reg;
    logic [BKT_W-1:0]         pend_b_reg;

    logic                     out_valid_reg, out_last_reg, out_ok_reg;
    logic [KIND_W-1:0]        out_kind_reg;
    logic [ID_W-1:0]          out_id_reg;
    logic [BUCKET_W-1:0]      out_b_reg;

    logic             out_free, store_full, emit, node_go, slot_re;
    logic [BKT_W-1:0] bkt_raddr, q_bkt;
    logic [IDX_W-1:0] slot_raddr, used_idx;

    assign out_free   = !out_valid_reg || m_tready;
    assign store_full = (used_reg == CNT_W'(CAPACITY));
    assign q_bkt      = q_data.bucket[BKT_W-1:0];
    assign used_idx   = used_reg[IDX_W-1:0];
    assign q_pop      = (state_reg == B_IDLE) && !q_empty && out_free;
    assign bkt_raddr  = (state_reg == B_IDLE) ? q_bkt : b_reg;
    assign node_go    = (state_reg == B_NODE) && (!pend_valid_reg || out_free);
    assign slot_re    = (state_reg == B_HT) || (node_go && cur_s_reg != cur_tail_reg);
    assign slot_raddr = (state_reg == B_HT) ? head_rd_reg : link_rd_reg;
    assign emit       = out_free && (
                            (q_pop && q_data.op == OP_ADD && store_full) ||
                            (state_reg == B_ADD) ||
                            (node_go && pend_valid_reg) ||
                            (state_reg == B_END));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ok_reg, out_b_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Memories: registered reads, one write port each.
    always_ff @(posedge aclk) begin
        head_rd_reg <= head_mem[bkt_raddr];
        tail_rd_reg <= tail_mem[bkt_raddr];
        if (slot_re) begin
            slot_rd_reg <= slot_mem[slot_raddr];
            link_rd_reg <= link_mem[slot_raddr];
        end
        if (state_reg == B_ADD) begin
            slot_mem[used_idx]  <= add_id_reg;
            tail_mem[add_b_reg] <= used_idx;
            if (!valid_reg[add_b_reg]) begin
                head_mem[add_b_reg] <= used_idx;
            end else begin
                link_mem[tail_rd_reg] <= used_idx;
            end
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_last_reg <= 1'b1;
            out_ok_reg   <= 1'b1;
            out_kind_reg <= KIND_NODE;
            if (state_reg == B_IDLE) begin
                out_kind_reg <= KIND_ACK;
                out_id_reg   <= q_data.node_id;
                out_b_reg    <= BUCKET_W'(q_bkt);
                out_ok_reg   <= 1'b0;
            end else if (state_reg == B_ADD) begin
                out_kind_reg <= KIND_ACK;
                out_id_reg   <= add_id_reg;
                out_b_reg    <= BUCKET_W'(add_b_reg);
            end else if (pend_valid_reg) begin
                out_id_reg   <= pend_id_reg;
                out_b_reg    <= BUCKET_W'(pend_b_reg);
                out_last_reg <= (state_reg == B_END);
            end else begin
                out_kind_reg <= KIND_EMPTY;
                out_id_reg   <= '0;
                out_b_reg    <= '0;
                out_ok_reg   <= 1'b0;
            end
        end
        if (q_pop) begin
            add_id_reg <= q_data.node_id;
            add_b_reg  <= q_bkt;
        end
        if (state_reg == B_HT) begin
            cur_s_reg    <= head_rd_reg;
            cur_tail_reg <= tail_rd_reg;
        end else if (slot_re) begin
            cur_s_reg <= link_rd_reg;
        end
        if (node_go) begin
            pend_id_reg <= slot_rd_reg;
            pend_b_reg  <= b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            n_reg          <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        b_reg <= '0;
                        n_reg <= '0;
                        if (q_data.op == OP_FLUSH) begin
                            state_reg <= B_SCAN;
                        end else if (!store_full) begin
                            state_reg <= B_ADD;
                        end
                    end
                end
                B_ADD: begin
                    valid_reg[add_b_reg] <= 1'b1;
                    used_reg             <= used_reg + 1'b1;
                    state_reg            <= B_IDLE;
                end
                B_SCAN: begin
                    if (n_reg == CNT_W'(CAPACITY)) begin
                        state_reg <= B_END;
                    end else if (valid_reg[b_reg]) begin
                        state_reg <= B_HT;
                    end else if (b_reg == BKT_W'(DEPTH_BUCKETS - 1)) begin
                        state_reg <= B_END;
                    end else begin
                        b_reg <= b_reg + 1'b1;
                    end
                end
                B_HT: state_reg <= B_NODE;
                B_NODE: begin
                    if (node_go) begin
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + 1'b1;
                        if (n_reg == CNT_W'(CAPACITY - 1)) begin
                            state_reg <= B_END;
                        end else if (cur_s_reg == cur_tail_reg) begin
                            if (b_reg == BKT_W'(DEPTH_BUCKETS - 1)) begin
                                state_reg <= B_END;
                            end else begin
                                b_reg     <= b_reg + 1'b1;
                                state_reg <= B_SCAN;
                            end
                        end
                    end
                end
                B_END: begin
                    if (out_free) begin
                        valid_reg      <= '0;
                        used_reg       <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(CAPACITY))
        else $error("used count beyond capacity");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_END && out_free) |=> (used_reg == '0 && valid_reg == '0))
        else $error("flush end did not clear the store");
    a_pend_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == B_SCAN || state_reg == B_HT ||
                            state_reg == B_NODE || state_reg == B_END))
        else $error("pending node outside a flush walk");
endmodule
`default_nettype wire

/* hw/rtl/depth_bucket_render_queue.sv */
// Top level of the depth bucket render queue: front, command queue and back end.
// An add is acknowledged after the six shared-multiplier steps of the depth product,
//   the command queue and the list update.
// The front takes no new item until it has pushed the current one; a flush scans
//   the buckets in order, with a head/tail read per used bucket and a step per stored node.
// A rotation write makes the front recompute its coefficients before the next item is taken.
// Reset (aresetn, synchronous, active low) empties all buckets and restores the
//   identity camera at the origin; list memories are not cleared.
`default_nettype none
module depth_bucket_render_queue #(
    parameter int DEPTH_BUCKETS = dbrq_pkg::DEPTH_BUCKETS_DEF,
    parameter int CAPACITY      = dbrq_pkg::CAPACITY_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration writes, index = register number
    input  wire                             cfg_we,
    input  wire  [dbrq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire  [dbrq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input word
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // node_id[15:0], node_pos_x[47:16], node_pos_y[79:48], node_pos_z[111:80]
    input  wire  [dbrq_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire                             s_tuser,
    // result word
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out_node_id[15:0], depth_bucket[22:16], stored_ok[23]
    output logic [dbrq_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [dbrq_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import dbrq_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t push_cmd, pop_cmd;

    // Front: camera state and bucket classification; hold input while busy.
    dbrq_front #(.DEPTH_BUCKETS(DEPTH_BUCKETS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (push_cmd),
        .q_full   (q_full)
    );

    // Queue: decouple classification from list work.
    dbrq_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (pop_cmd),
        .empty    (q_empty)
    );

    // Back: append to bucket lists, walk them on flush, drive the result word.
    dbrq_back #(.DEPTH_BUCKETS(DEPTH_BUCKETS), .CAPACITY(CAPACITY)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (pop_cmd),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );
endmodule
`default_nettype wire
